@@ rtl/slt_pkg.sv @@
// shared types and constants for the sorted list table
package slt_pkg;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int MODE_W   = 2;

  // configuration register index, taken from paddr[2]
  localparam logic [0:0] REG_ASCENDING = 1'b0;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_DUMP   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SEARCH,
    ST_DUMP,
    ST_CLEAR
  } state_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_DONE,
    EMIT_FULL,
    EMIT_FOUND,
    EMIT_EMPTY,
    EMIT_ENTRY
  } emit_t;

  typedef struct packed {
    logic  take;
    logic  idx_clr;
    logic  idx_inc;
    logic  insert;
    logic  cnt_clr;
    emit_t emit;
  } dp_cmd_t;

  typedef struct packed {
    logic at_end;
    logic gt;
    logic eq;
    logic full;
    logic empty;
    logic last_idx;
  } dp_stat_t;

endpackage

@@ rtl/slt_if.sv @@
// valid/ready channels for request and result items
interface slt_in_if;
  logic                                valid;
  logic                                ready;
  logic [slt_pkg::MODE_W-1:0]          mode;
  logic signed [slt_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface slt_out_if;
  logic                                valid;
  logic                                ready;
  logic [slt_pkg::STATUS_W-1:0]        status;
  logic                                found;
  logic [slt_pkg::POS_W-1:0]           position;
  logic signed [slt_pkg::VALUE_W-1:0]  entry_value;
  logic                                last;

  modport source (output valid, output status, output found, output position,
                  output entry_value, output last, input ready);
  modport sink   (input valid, input status, input found, input position,
                  input entry_value, input last, output ready);
endinterface

@@ rtl/slt_dp.sv @@
// datapath: entry cells, scan index, count, order flag and result register
module slt_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_asc,
  output logic                                asc,
  input  logic signed [slt_pkg::VALUE_W-1:0]  in_value,
  input  slt_pkg::dp_cmd_t                    cmd,
  output slt_pkg::dp_stat_t                   stat,
  output logic [slt_pkg::STATUS_W-1:0]        status,
  output logic                                found,
  output logic [slt_pkg::POS_W-1:0]           position,
  output logic signed [slt_pkg::VALUE_W-1:0]  entry_value,
  output logic                                last
);

  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic signed [slt_pkg::VALUE_W-1:0] entries [CAPACITY];
  logic signed [slt_pkg::VALUE_W-1:0] value_q;
  logic signed [slt_pkg::VALUE_W-1:0] rd;
  logic [CNTW-1:0]                    count;
  logic [CNTW-1:0]                    idx;
  logic [CNTW+slt_pkg::POS_W-1:0]     idx_ext;

  // order flag
  always_ff @(posedge clk) begin
    if (rst) begin
      asc <= 1'b1;
    end else if (cfg_we) begin
      asc <= cfg_asc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      value_q <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_clr) begin
      count <= '0;
    end else if (cmd.insert) begin
      count <= count + CNTW'(1);
    end
  end

  // insert writes the new value at idx and moves the tail up by one cell
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (cmd.insert && idx == CNTW'(i)) begin
          entries[i] <= value_q;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (cmd.insert) begin
          if (idx == CNTW'(i)) begin
            entries[i] <= value_q;
          end else if (idx < CNTW'(i) && CNTW'(i) <= count) begin
            entries[i] <= entries[i-1];
          end
        end
      end
    end
  end

  // single read port shared by scan and dump
  always_comb begin
    rd = '0;
    if (idx < CNTW'(CAPACITY)) begin
      rd = entries[idx[IDXW-1:0]];
    end
  end

  always_comb begin
    stat.at_end   = (idx == count);
    stat.gt       = asc ? (rd > value_q) : (rd < value_q);
    stat.eq       = (rd == value_q);
    stat.full     = (count == CNTW'(CAPACITY));
    stat.empty    = (count == '0);
    stat.last_idx = ((idx + CNTW'(1)) == count);
  end

  assign idx_ext = {{slt_pkg::POS_W{1'b0}}, idx};

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit != slt_pkg::EMIT_NONE) begin
      status      <= slt_pkg::STATUS_DONE;
      found       <= 1'b0;
      position    <= '0;
      entry_value <= '0;
      last        <= 1'b1;
      unique case (cmd.emit)
        slt_pkg::EMIT_FULL:  status <= slt_pkg::STATUS_FULL;
        slt_pkg::EMIT_EMPTY: status <= slt_pkg::STATUS_EMPTY;
        slt_pkg::EMIT_FOUND: begin
          found    <= 1'b1;
          position <= idx_ext[slt_pkg::POS_W-1:0];
        end
        slt_pkg::EMIT_ENTRY: begin
          position    <= idx_ext[slt_pkg::POS_W-1:0];
          entry_value <= rd;
          last        <= stat.last_idx;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/slt_ctrl.sv @@
// controller: sequences insert scan, search scan, dump stream and clear
module slt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [slt_pkg::MODE_W-1:0] in_mode,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  slt_pkg::dp_stat_t  stat,
  output slt_pkg::dp_cmd_t   cmd
);

  slt_pkg::state_t state, state_next;
  logic            out_valid_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= slt_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      slt_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (slt_pkg::mode_t'(in_mode))
            slt_pkg::MODE_INSERT: state_next = slt_pkg::ST_INSERT;
            slt_pkg::MODE_SEARCH: state_next = slt_pkg::ST_SEARCH;
            slt_pkg::MODE_DUMP:   state_next = slt_pkg::ST_DUMP;
            slt_pkg::MODE_CLEAR:  state_next = slt_pkg::ST_CLEAR;
            default:              state_next = slt_pkg::ST_IDLE;
          endcase
        end
      end
      slt_pkg::ST_INSERT: begin
        if (out_free && (stat.full || stat.at_end || stat.gt)) begin
          state_next = slt_pkg::ST_IDLE;
        end
      end
      slt_pkg::ST_SEARCH: begin
        if (out_free && (stat.at_end || stat.eq)) begin
          state_next = slt_pkg::ST_IDLE;
        end
      end
      slt_pkg::ST_DUMP: begin
        if (out_free && (stat.empty || stat.last_idx)) begin
          state_next = slt_pkg::ST_IDLE;
        end
      end
      slt_pkg::ST_CLEAR: begin
        if (out_free) begin
          state_next = slt_pkg::ST_IDLE;
        end
      end
      default: state_next = slt_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.emit = slt_pkg::EMIT_NONE;
    in_ready = 1'b0;
    unique case (state)
      slt_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.take    = in_valid;
        cmd.idx_clr = in_valid;
      end
      slt_pkg::ST_INSERT: begin
        if (stat.full) begin
          if (out_free) begin
            cmd.emit = slt_pkg::EMIT_FULL;
          end
        end else if (stat.at_end || stat.gt) begin
          if (out_free) begin
            cmd.insert = 1'b1;
            cmd.emit   = slt_pkg::EMIT_DONE;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      slt_pkg::ST_SEARCH: begin
        if (stat.at_end) begin
          if (out_free) begin
            cmd.emit = slt_pkg::EMIT_DONE;
          end
        end else if (stat.eq) begin
          if (out_free) begin
            cmd.emit = slt_pkg::EMIT_FOUND;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      slt_pkg::ST_DUMP: begin
        if (out_free) begin
          if (stat.empty) begin
            cmd.emit = slt_pkg::EMIT_EMPTY;
          end else begin
            cmd.emit    = slt_pkg::EMIT_ENTRY;
            cmd.idx_inc = 1'b1;
          end
        end
      end
      slt_pkg::ST_CLEAR: begin
        if (out_free) begin
          cmd.cnt_clr = 1'b1;
          cmd.emit    = slt_pkg::EMIT_DONE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.emit != slt_pkg::EMIT_NONE) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

@@ rtl/sorted_list_table_core.sv @@
// Sorted table of up to CAPACITY signed 32-bit values, one request item at a time. A request
// is taken, then worked on by a scan over the entry cells through a single read port, one
// cell per cycle: an insert scans up to the index it lands at (a full table answers with no
// scan), a search scans up to a hit or the end, a dump emits one result item per cycle while
// the sink takes them (one item for an empty table), and a clear empties it. The insert
// moves the tail up by one cell in the same cycle that it writes the new value. Results
// sit in an output register, so a new request is taken while the last result still waits;
// result items are emitted only as fast as the sink takes them. The order flag (register 0,
// bit 0: 1 ascending) is written over the APB port by the user only while idle, unchecked.
module sorted_list_table_core #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  slt_in_if.sink      in_ch,
  slt_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  slt_pkg::dp_cmd_t  cmd;
  slt_pkg::dp_stat_t stat;
  logic              cfg_we;
  logic              asc;
  logic              reg_hit;

  assign reg_hit = (paddr[2:2] == slt_pkg::REG_ASCENDING);
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {31'b0, asc} : 32'b0;

  slt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  slt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_asc     (pwdata[0]),
    .asc         (asc),
    .in_value    (in_ch.value),
    .cmd         (cmd),
    .stat        (stat),
    .status      (out_ch.status),
    .found       (out_ch.found),
    .position    (out_ch.position),
    .entry_value (out_ch.entry_value),
    .last        (out_ch.last)
  );

endmodule

@@ rtl/slt_checker.sv @@
// port-level checks for the sorted list table, bound to the top level
module slt_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [slt_pkg::STATUS_W-1:0]        out_status,
  input logic                                out_found,
  input logic [slt_pkg::POS_W-1:0]           out_position,
  input logic signed [slt_pkg::VALUE_W-1:0]  out_entry_value,
  input logic                                out_last
);

  // a waiting result item holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_found)
      && $stable(out_position) && $stable(out_entry_value) && $stable(out_last))
    else $error("result item changed while stalled");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous still in work");

  // a dump in progress keeps the request side closed
  a_dump_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |-> !in_ready)
    else $error("request taken in the middle of a dump");

  // dropped inserts and empty dumps are single final items without a hit
  a_flag_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != slt_pkg::STATUS_DONE |-> out_last && !out_found)
    else $error("flagged result item not final or marked found");

endmodule

bind sorted_list_table_core slt_checker u_slt_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_found       (out_ch.found),
  .out_position    (out_ch.position),
  .out_entry_value (out_ch.entry_value),
  .out_last        (out_ch.last)
);
